/* rtl/spip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spip_pkg
// Shared types and constants of the servo packet intercept parser.
// ----------------------------------------------------------------------------
package spip_pkg;

   localparam int DefMaxSyncDevices = 32;

   localparam logic [7:0] ByteSync    = 8'hFF;
   localparam logic [7:0] IdBroadcast = 8'hFE;
   localparam logic [7:0] ChecksumOk  = 8'hFF;
   localparam logic [7:0] OpPing      = 8'd1;
   localparam logic [7:0] OpRead      = 8'd2;
   localparam logic [7:0] OpWrite     = 8'd3;
   localparam logic [7:0] OpReset     = 8'd6;

   localparam logic [2:0] KindFwd    = 3'd0;
   localparam logic [2:0] KindStatus = 3'd1;
   localparam logic [2:0] KindReq    = 3'd2;
   localparam logic [2:0] KindReset  = 3'd3;
   localparam logic [2:0] KindBoot   = 3'd4;

   localparam logic [1:0] RtSync  = 2'd0;
   localparam logic [1:0] RtRead  = 2'd1;
   localparam logic [1:0] RtWrite = 2'd2;

   localparam logic ErrNone  = 1'b0;
   localparam logic ErrRange = 1'b1;

   localparam logic CmdByte = 1'b0;
   localparam logic CmdTick = 1'b1;

   localparam logic [2:0] CsrDeviceId     = 3'd0;
   localparam logic [2:0] CsrRxTimeout    = 3'd1;
   localparam logic [2:0] CsrSyncReadOp   = 3'd2;
   localparam logic [2:0] CsrBootloadOp   = 3'd3;
   localparam logic [2:0] CsrMaxServoRply = 3'd4;
   localparam logic [2:0] CsrMaxHostRply  = 3'd5;

   localparam logic [7:0]  RstDeviceId  = 8'd253;
   localparam logic [7:0]  RstTimeout   = 8'd100;
   localparam logic [7:0]  RstSyncOp    = 8'd132;
   localparam logic [7:0]  RstBootOp    = 8'd8;
   localparam logic [7:0]  RstMaxServo  = 8'd249;
   localparam logic [11:0] RstMaxHost   = 12'd249;

   typedef struct packed {
      logic [7:0]  device_id;
      logic [7:0]  rx_timeout;
      logic [7:0]  sync_op;
      logic [7:0]  boot_op;
      logic [7:0]  max_servo;
      logic [11:0] max_host;
   } cfg_type;

   typedef enum logic [9:0] {
      PS_HUNT1  = 10'b0000000001,
      PS_HUNT2  = 10'b0000000010,
      PS_ID     = 10'b0000000100,
      PS_LEN    = 10'b0000001000,
      PS_CMD    = 10'b0000010000,
      PS_RESET  = 10'b0000100000,
      PS_BOOT   = 10'b0001000000,
      PS_PARAMS = 10'b0010000000,
      PS_PING   = 10'b0100000000,
      PS_PASS   = 10'b1000000000
   } pstate_type;

   typedef enum logic [4:0] {
      CS_IDLE     = 5'b00001,
      CS_DISPATCH = 5'b00010,
      CS_PRE      = 5'b00100,
      CS_FETCH    = 5'b01000,
      CS_SHOW     = 5'b10000
   } cstate_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic advance;
      logic show_pre;
   } ctl_cmd_type;

   typedef struct packed {
      logic pre_v;
      logic seq_zero;
      logic seq_one;
   } dp_sts_type;

endpackage

/* rtl/spip_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spip_csr
// Configuration register file.
// ----------------------------------------------------------------------------
module spip_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [11:0]        csr_wdata,
   output spip_pkg::cfg_type  cfg
);
   import spip_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrDeviceId:     cfg_in.device_id  = csr_wdata[7:0];
            CsrRxTimeout:    cfg_in.rx_timeout = csr_wdata[7:0];
            CsrSyncReadOp:   cfg_in.sync_op    = csr_wdata[7:0];
            CsrBootloadOp:   cfg_in.boot_op    = csr_wdata[7:0];
            CsrMaxServoRply: cfg_in.max_servo  = csr_wdata[7:0];
            CsrMaxHostRply:  cfg_in.max_host   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_id  <= RstDeviceId;
         cfg_ff.rx_timeout <= RstTimeout;
         cfg_ff.sync_op    <= RstSyncOp;
         cfg_ff.boot_op    <= RstBootOp;
         cfg_ff.max_servo  <= RstMaxServo;
         cfg_ff.max_host   <= RstMaxHost;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/spip_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spip_ctrl
// Sequencer: takes one transaction, then emits its results one at a time.
// ----------------------------------------------------------------------------
module spip_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  spip_pkg::dp_sts_type   sts,
   output spip_pkg::ctl_cmd_type  cmd
);
   import spip_pkg::*;

   cstate_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = CS_DISPATCH;
            end
         end
         CS_DISPATCH: begin
            if (sts.pre_v)        state_in = CS_PRE;
            else if (!sts.seq_zero) state_in = CS_FETCH;
            else                  state_in = CS_IDLE;
         end
         CS_PRE: begin
            rsp_valid    = 1'b1;
            cmd.show_pre = 1'b1;
            if (rsp_ready) state_in = sts.seq_zero ? CS_IDLE : CS_FETCH;
         end
         CS_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = CS_SHOW;
         end
         CS_SHOW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               state_in    = sts.seq_one ? CS_IDLE : CS_FETCH;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/spip_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spip_dp
// Parser registers, packet buffer and result generation.
// ----------------------------------------------------------------------------
module spip_dp #(
   parameter int MaxSyncDevices = spip_pkg::DefMaxSyncDevices
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_command,
   input  logic [7:0]             req_data,
   input  spip_pkg::cfg_type      cfg,
   input  spip_pkg::ctl_cmd_type  cmd,
   output spip_pkg::dp_sts_type   sts,
   output logic [2:0]             rsp_kind,
   output logic [7:0]             rsp_data_res,
   output logic [1:0]             rsp_request_type,
   output logic                   rsp_error_code,
   output logic                   rsp_last
);
   import spip_pkg::*;

   localparam int Depth = MaxSyncDevices + 8;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(Depth + 1);
   localparam logic [8:0] LenLimit = 9'(MaxSyncDevices + 4);
   localparam logic [8:0] DepthC   = 9'(Depth);

   // parser state
   pstate_type pst_ff, pst_in;
   logic [8:0] bc_ff, bc_in;
   logic [7:0] cs_ff, cs_in;
   logic [7:0] idle_ff, idle_in;
   logic [7:0] id_ff, id_in, len_ff, len_in, ins_ff, ins_in, rl_ff, rl_in;

   // result plan
   logic          pre_v_ff, pre_v_in;
   logic [2:0]    pre_kind_ff, pre_kind_in;
   logic [7:0]    pre_data_ff, pre_data_in;
   logic          pre_err_ff, pre_err_in;
   logic [CW-1:0] seq_left_ff, seq_left_in;
   logic [AW-1:0] seq_addr_ff, seq_addr_in;
   logic [2:0]    seq_kind_ff, seq_kind_in;
   logic [1:0]    seq_rt_ff, seq_rt_in;

   logic [7:0]    buf_mem [Depth];
   logic [7:0]    rd_q;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic          rej;
   logic [8:0]    rej_c;
   logic [7:0]    b, s3, s4, idle_inc, rl_cur;
   logic [8:0]    bc_inc;
   logic [9:0]    pkt_end;
   logic [15:0]   prod;
   logic          b_sync;

   assign b        = req_data;
   assign b_sync   = (b == ByteSync);
   assign s3       = id_ff + b + len_ff;
   assign s4       = cfg.device_id + len_ff + ins_ff + b;
   assign idle_inc = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 8'd1;
   assign bc_inc   = bc_ff + 9'd1;
   assign pkt_end  = {2'b00, len_ff} + 10'd4;
   assign rl_cur   = (bc_ff == 9'd6) ? b : rl_ff;
   assign prod     = {8'd0, rl_cur} * {8'd0, len_ff - 8'd4};

   always_comb begin
      pst_in      = pst_ff;
      bc_in       = bc_ff;
      cs_in       = cs_ff;
      idle_in     = idle_ff;
      id_in       = id_ff;
      len_in      = len_ff;
      ins_in      = ins_ff;
      rl_in       = rl_ff;
      pre_v_in    = 1'b0;
      pre_kind_in = KindFwd;
      pre_data_in = 8'd0;
      pre_err_in  = ErrNone;
      seq_left_in = '0;
      seq_addr_in = '0;
      seq_kind_in = KindFwd;
      seq_rt_in   = RtSync;
      wr_en       = 1'b0;
      wr_addr     = '0;
      rej         = 1'b0;
      rej_c       = 9'd0;

      if (req_command == CmdTick) begin
         idle_in = idle_inc;
         if (pst_ff != PS_HUNT1 && idle_inc > cfg.rx_timeout) begin
            if (pst_ff != PS_PASS)
               seq_left_in = (bc_ff > DepthC) ? CW'(Depth) : CW'(bc_ff);
            pst_in = PS_HUNT1;
            bc_in  = 9'd0;
         end
      end else begin
         unique case (pst_ff)
            PS_HUNT2: begin
               wr_en   = 1'b1;
               wr_addr = AW'(1);
               bc_in   = 9'd2;
               if (b_sync) begin
                  pst_in  = PS_ID;
                  idle_in = 8'd0;
               end else begin
                  rej   = 1'b1;
                  rej_c = 9'd2;
               end
            end
            PS_ID: begin
               wr_en   = 1'b1;
               wr_addr = AW'(2);
               idle_in = 8'd0;
               id_in   = b;
               if (b_sync) begin
                  pre_v_in    = 1'b1;
                  pre_data_in = ByteSync;
                  bc_in       = 9'd2;
               end else begin
                  bc_in  = 9'd3;
                  pst_in = PS_LEN;
               end
            end
            PS_LEN: begin
               wr_en   = 1'b1;
               wr_addr = AW'(3);
               bc_in   = 9'd4;
               len_in  = b;
               if (id_ff == cfg.device_id || id_ff == IdBroadcast) begin
                  if (b > 8'd1 && {1'b0, b} < LenLimit) begin
                     pst_in  = PS_CMD;
                     idle_in = 8'd0;
                  end else begin
                     pre_v_in    = 1'b1;
                     pre_kind_in = KindStatus;
                     pre_err_in  = ErrRange;
                     rej         = 1'b1;
                     rej_c       = 9'd4;
                  end
               end else begin
                  seq_left_in = CW'(4);
                  pst_in      = PS_PASS;
                  idle_in     = 8'd0;
               end
            end
            PS_CMD: begin
               wr_en   = 1'b1;
               wr_addr = AW'(4);
               bc_in   = 9'd5;
               ins_in  = b;
               if (b == cfg.sync_op) begin
                  pst_in  = PS_PARAMS;
                  cs_in   = s3;
                  idle_in = 8'd0;
               end else if (id_ff == cfg.device_id) begin
                  idle_in = 8'd0;
                  if (b == OpPing) pst_in = PS_PING;
                  else if (b == OpReset) pst_in = PS_RESET;
                  else if (b == cfg.boot_op) pst_in = PS_BOOT;
                  else if (b == OpRead || b == OpWrite) begin
                     pst_in = PS_PARAMS;
                     cs_in  = s3;
                  end else begin
                     rej   = 1'b1;
                     rej_c = 9'd5;
                  end
               end else begin
                  rej   = 1'b1;
                  rej_c = 9'd5;
               end
            end
            PS_PING, PS_RESET, PS_BOOT: begin
               wr_en   = 1'b1;
               wr_addr = AW'(5);
               bc_in   = 9'd6;
               if (s4 == ChecksumOk) begin
                  pre_v_in    = 1'b1;
                  pre_kind_in = (pst_ff == PS_PING)  ? KindStatus :
                                (pst_ff == PS_RESET) ? KindReset : KindBoot;
                  pst_in      = PS_HUNT1;
                  bc_in       = 9'd0;
               end else begin
                  rej   = 1'b1;
                  rej_c = 9'd6;
               end
            end
            PS_PARAMS: begin
               wr_en   = (bc_ff < DepthC);
               wr_addr = bc_ff[AW-1:0];
               if (bc_ff == 9'd6) rl_in = b;
               cs_in   = cs_ff + b;
               bc_in   = bc_inc;
               idle_in = 8'd0;
               if ({1'b0, bc_inc} >= pkt_end) begin
                  if (cs_in != ChecksumOk) begin
                     rej   = 1'b1;
                     rej_c = bc_inc;
                  end else begin
                     pst_in      = PS_HUNT1;
                     bc_in       = 9'd0;
                     seq_addr_in = AW'(5);
                     seq_kind_in = KindReq;
                     if (ins_ff == cfg.sync_op) begin
                        if (len_ff < 8'd4 || rl_cur == 8'd0 || rl_cur > cfg.max_servo ||
                            prod > {4'd0, cfg.max_host}) begin
                           pre_v_in    = 1'b1;
                           pre_kind_in = KindStatus;
                           pre_err_in  = ErrRange;
                        end else begin
                           seq_left_in = CW'(len_ff - 8'd2);
                           seq_rt_in   = RtSync;
                        end
                     end else if (ins_ff == OpRead) begin
                        seq_left_in = CW'(len_ff - 8'd2);
                        seq_rt_in   = RtRead;
                     end else if (ins_ff == OpWrite) begin
                        seq_left_in = CW'(len_ff - 8'd2);
                        seq_rt_in   = RtWrite;
                     end
                  end
               end
            end
            PS_PASS: begin
               pre_v_in    = 1'b1;
               pre_data_in = b;
               bc_in       = bc_inc;
               idle_in     = 8'd0;
               if ({1'b0, bc_inc} >= pkt_end) begin
                  pst_in = PS_HUNT1;
                  bc_in  = 9'd0;
               end
            end
            default: begin
               if (b_sync) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(0);
                  bc_in   = 9'd1;
                  pst_in  = PS_HUNT2;
                  idle_in = 8'd0;
               end else begin
                  pst_in      = PS_HUNT1;
                  pre_v_in    = 1'b1;
                  pre_data_in = b;
               end
            end
         endcase

         // bad packet: replay the buffer, keeping a trailing FF as a new start
         if (rej) begin
            seq_addr_in = '0;
            seq_kind_in = KindFwd;
            seq_rt_in   = RtSync;
            if (rej_c > DepthC) begin
               seq_left_in = CW'(Depth);
               pst_in      = PS_HUNT1;
               bc_in       = 9'd0;
            end else if (b_sync) begin
               seq_left_in = CW'(rej_c - 9'd1);
               pst_in      = PS_HUNT2;
               bc_in       = 9'd1;
               idle_in     = 8'd0;
            end else begin
               seq_left_in = CW'(rej_c);
               pst_in      = PS_HUNT1;
               bc_in       = 9'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff      <= PS_HUNT1;
         bc_ff       <= 9'd0;
         cs_ff       <= 8'd0;
         idle_ff     <= 8'd0;
         pre_v_ff    <= 1'b0;
         seq_left_ff <= '0;
      end else if (cmd.accept) begin
         pst_ff      <= pst_in;
         bc_ff       <= bc_in;
         cs_ff       <= cs_in;
         idle_ff     <= idle_in;
         pre_v_ff    <= pre_v_in;
         seq_left_ff <= seq_left_in;
      end else if (cmd.advance) begin
         seq_left_ff <= seq_left_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff       <= id_in;
         len_ff      <= len_in;
         ins_ff      <= ins_in;
         rl_ff       <= rl_in;
         pre_kind_ff <= pre_kind_in;
         pre_data_ff <= pre_data_in;
         pre_err_ff  <= pre_err_in;
         seq_addr_ff <= seq_addr_in;
         seq_kind_ff <= seq_kind_in;
         seq_rt_ff   <= seq_rt_in;
      end else if (cmd.advance) begin
         seq_addr_ff <= seq_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_command == CmdByte && wr_en)
         buf_mem[wr_addr] <= b;
      if (cmd.fetch)
         rd_q <= buf_mem[seq_addr_ff];
   end

   assign sts.pre_v    = pre_v_ff;
   assign sts.seq_zero = (seq_left_ff == '0);
   assign sts.seq_one  = (seq_left_ff == CW'(1));

   assign rsp_kind         = cmd.show_pre ? pre_kind_ff : seq_kind_ff;
   assign rsp_data_res     = cmd.show_pre ? pre_data_ff : rd_q;
   assign rsp_request_type = cmd.show_pre ? RtSync : seq_rt_ff;
   assign rsp_error_code   = cmd.show_pre ? pre_err_ff : ErrNone;
   assign rsp_last         = cmd.show_pre ? sts.seq_zero : sts.seq_one;

endmodule

/* rtl/servo_packet_intercept_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_packet_intercept_parser
// Hunts servo bus packets in host bytes; forwards foreign traffic and turns
// packets for the bridge into status, reset, bootload or request results.
// ----------------------------------------------------------------------------
// channel  | ports                                        | direction
// req_     | valid ready command data                     | in
// rsp_     | valid ready kind data_res request_type       | out
//          | error_code last                              |
// csr_     | valid ready index wdata                      | in
//
// One transaction is taken, then its results leave one at a time; bytes read
// back from the packet buffer pass one read port with registered data. A
// packet ends by byte 39 at the default depth, so at most 39 buffered
// results per item. Reset is synchronous; the buffer needs no clearing.
// A stalled rsp_ holds the sequencer and req_ready stays low until all
// results are taken.
// ----------------------------------------------------------------------------
module servo_packet_intercept_parser #(
   parameter int MaxSyncDevices = spip_pkg::DefMaxSyncDevices
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_res,
   output logic [1:0]  rsp_request_type,
   output logic        rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import spip_pkg::*;

   cfg_type     cfg;
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   spip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spip_dp #(
      .MaxSyncDevices (MaxSyncDevices)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_data         (req_data),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_kind         (rsp_kind),
      .rsp_data_res     (rsp_data_res),
      .rsp_request_type (rsp_request_type),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for servo_packet_intercept_parser: packets, noise and
// timer ticks go in through req_, a scoreboard with its own parser model
// predicts every rsp_ transaction, and settings change through csr_ between
// phases.
// ----------------------------------------------------------------------------
module testbench;
   import spip_pkg::*;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] data_res;
      logic [1:0] request_type;
      logic       error_code;
      logic       last;
   } parse_result_type;

   localparam int BufDepth = DefMaxSyncDevices + 8;
   localparam int MaxPerItem = 40;

   class parse_scoreboard_type;
      cfg_type          cfg;
      pstate_type       st;
      logic [7:0]       pbuf[BufDepth];
      int unsigned      cnt, csum, idle;
      parse_result_type expected_q[$];
      parse_result_type step_q[$];
      int               errors;

      function new();
         cfg = '{RstDeviceId, RstTimeout, RstSyncOp, RstBootOp, RstMaxServo, RstMaxHost};
         st = PS_HUNT1;
         cnt = 0;
         csum = 0;
         idle = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [11:0] v);
         case (idx)
            CsrDeviceId:     cfg.device_id = v[7:0];
            CsrRxTimeout:    cfg.rx_timeout = v[7:0];
            CsrSyncReadOp:   cfg.sync_op = v[7:0];
            CsrBootloadOp:   cfg.boot_op = v[7:0];
            CsrMaxServoRply: cfg.max_servo = v[7:0];
            CsrMaxHostRply:  cfg.max_host = v;
            default: ;
         endcase
      endfunction

      function void emit(logic [2:0] k, logic [7:0] d, logic [1:0] rt, logic e);
         parse_result_type r;
         if (step_q.size() < MaxPerItem) begin
            r = '{k, d, rt, e, 1'b0};
            step_q.push_back(r);
         end
      endfunction

      function void replay(int unsigned c);
         for (int unsigned i = 0; i < c && i < BufDepth; i++)
            emit(KindFwd, pbuf[i], RtSync, ErrNone);
      endfunction

      function void reject();
         int unsigned c;
         c = cnt;
         if (c == 0 || c > BufDepth) begin
            replay(c);
            st = PS_HUNT1;
            cnt = 0;
         end else if (pbuf[c-1] == ByteSync) begin
            // trailing FF may start the next packet
            replay(c - 1);
            st = PS_HUNT2;
            cnt = 1;
            idle = 0;
         end else begin
            replay(c);
            st = PS_HUNT1;
            cnt = 0;
         end
      endfunction

      function void finish_request();
         int unsigned len, ins, np, rl;
         logic [1:0] rt;
         len = pbuf[3];
         ins = pbuf[4];
         np = (len >= 2) ? len - 2 : 0;
         if (ins == cfg.sync_op) begin
            rl = pbuf[6];
            if (len < 4 || rl == 0 || rl > cfg.max_servo || rl * (len - 4) > cfg.max_host) begin
               emit(KindStatus, 8'd0, RtSync, ErrRange);
               return;
            end
            rt = RtSync;
         end else if (ins == OpRead) rt = RtRead;
         else if (ins == OpWrite) rt = RtWrite;
         else return;
         for (int unsigned i = 0; i < np && 5 + i < BufDepth; i++)
            emit(KindReq, pbuf[5+i], rt, ErrNone);
      endfunction

      function void take_byte(logic [7:0] b);
         int unsigned id, s;
         case (st)
            PS_HUNT2: begin
               pbuf[1] = b;
               cnt = 2;
               if (b == ByteSync) begin
                  st = PS_ID;
                  idle = 0;
               end else reject();
            end
            PS_ID: begin
               pbuf[2] = b;
               idle = 0;
               if (b == ByteSync) begin
                  emit(KindFwd, ByteSync, RtSync, ErrNone);
                  cnt = 2;
               end else begin
                  cnt = 3;
                  st = PS_LEN;
               end
            end
            PS_LEN: begin
               pbuf[3] = b;
               cnt = 4;
               id = pbuf[2];
               if (id == cfg.device_id || id == IdBroadcast) begin
                  if (b > 1 && b < DefMaxSyncDevices + 4) begin
                     st = PS_CMD;
                     idle = 0;
                  end else begin
                     emit(KindStatus, 8'd0, RtSync, ErrRange);
                     reject();
                  end
               end else begin
                  replay(4);
                  st = PS_PASS;
                  idle = 0;
               end
            end
            PS_CMD: begin
               pbuf[4] = b;
               cnt = 5;
               id = pbuf[2];
               s = (id + b + pbuf[3]) & 8'hFF;
               if (b == cfg.sync_op) begin
                  st = PS_PARAMS;
                  csum = s;
                  idle = 0;
               end else if (id == cfg.device_id) begin
                  idle = 0;
                  if (b == OpPing) st = PS_PING;
                  else if (b == OpReset) st = PS_RESET;
                  else if (b == cfg.boot_op) st = PS_BOOT;
                  else if (b == OpRead || b == OpWrite) begin
                     st = PS_PARAMS;
                     csum = s;
                  end else reject();
               end else reject();
            end
            PS_PING, PS_RESET, PS_BOOT: begin
               pbuf[5] = b;
               cnt = 6;
               s = (cfg.device_id + pbuf[3] + pbuf[4] + b) & 8'hFF;
               if (s == ChecksumOk) begin
                  if (st == PS_PING) emit(KindStatus, 8'd0, RtSync, ErrNone);
                  else if (st == PS_RESET) emit(KindReset, 8'd0, RtSync, ErrNone);
                  else emit(KindBoot, 8'd0, RtSync, ErrNone);
                  st = PS_HUNT1;
                  cnt = 0;
               end else reject();
            end
            PS_PARAMS: begin
               if (cnt < BufDepth) pbuf[cnt] = b;
               csum = (csum + b) & 8'hFF;
               cnt = (cnt + 1) & 9'h1FF;
               idle = 0;
               if (cnt >= pbuf[3] + 4) begin
                  if (csum != ChecksumOk) reject();
                  else begin
                     finish_request();
                     st = PS_HUNT1;
                     cnt = 0;
                  end
               end
            end
            PS_PASS: begin
               emit(KindFwd, b, RtSync, ErrNone);
               cnt = (cnt + 1) & 9'h1FF;
               idle = 0;
               if (cnt >= pbuf[3] + 4) begin
                  st = PS_HUNT1;
                  cnt = 0;
               end
            end
            default: begin
               if (b == ByteSync) begin
                  pbuf[0] = ByteSync;
                  cnt = 1;
                  st = PS_HUNT2;
                  idle = 0;
               end else begin
                  st = PS_HUNT1;
                  emit(KindFwd, b, RtSync, ErrNone);
               end
            end
         endcase
      endfunction

      function void note_item(logic cmd, logic [7:0] b);
         step_q.delete();
         if (cmd == CmdTick) begin
            if (idle < 255) idle++;
            if (st != PS_HUNT1 && idle > cfg.rx_timeout) begin
               if (st != PS_PASS) replay(cnt);
               st = PS_HUNT1;
               cnt = 0;
            end
         end else take_byte(b);
         if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      endfunction

      function void check_result(parse_result_type got);
         parse_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d data=%02h", $time, got.kind,
                     got.data_res);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         if (got.kind !== exp_r.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
            errors++;
         end
         if (got.data_res !== exp_r.data_res) begin
            $display("%0t: data_res expected %02h actual %02h", $time, exp_r.data_res,
                     got.data_res);
            errors++;
         end
         if (got.request_type !== exp_r.request_type) begin
            $display("%0t: request_type expected %0d actual %0d", $time,
                     exp_r.request_type, got.request_type);
            errors++;
         end
         if (got.error_code !== exp_r.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time, exp_r.error_code,
                     got.error_code);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CmdByte;
   logic [7:0]  req_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_res;
   logic [1:0]  rsp_request_type;
   logic        rsp_error_code;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CsrDeviceId;
   logic [11:0] csr_wdata = 12'd0;

   parse_scoreboard_type parse_sb = new();
   bit  quiet = 0;
   bit  long_hold = 0;
   int  items_sent = 0;
   int  cycles = 0;

   servo_packet_intercept_parser dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: check, then choose next rsp_ready
   initial begin
      int hold;
      parse_result_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_data_res, rsp_request_type, rsp_error_code, rsp_last};
            parse_sb.check_result(got);
         end
         if (long_hold) begin
            long_hold = 0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic cmd, logic [7:0] b);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data <= b;
      do @(posedge clock); while (!req_ready);
      parse_sb.note_item(cmd, b);
      items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(CmdTick, 8'($urandom));
   endtask

   // FF FF id len ins params checksum; corrupt flips the checksum
   task automatic send_packet(logic [7:0] id, logic [7:0] ins, logic [7:0] params[$],
                              bit corrupt);
      logic [7:0] len, sum;
      len = 8'(params.size() + 2);
      sum = id + len + ins;
      foreach (params[i]) sum += params[i];
      sum = ~sum;
      if (corrupt) sum ^= 8'(1 << $urandom_range(0, 7));
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, id);
      send_item(CmdByte, len);
      send_item(CmdByte, ins);
      foreach (params[i]) send_item(CmdByte, params[i]);
      send_item(CmdByte, sum);
   endtask

   task automatic send_sync_read(logic [7:0] id, int nservo, logic [7:0] rl, bit corrupt);
      logic [7:0] p[$];
      p.push_back(8'($urandom));
      p.push_back(rl);
      repeat (nservo) p.push_back(8'($urandom_range(0, 253)));
      send_packet(id, parse_sb.cfg.sync_op, p, corrupt);
   endtask

   task automatic send_foreign();
      logic [7:0] id, len;
      do id = 8'($urandom);
      while (id == parse_sb.cfg.device_id || id == IdBroadcast || id == ByteSync);
      len = 8'($urandom_range(0, 12));
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, id);
      send_item(CmdByte, len);
      repeat (len) send_item(CmdByte, 8'($urandom));
   endtask

   task automatic csr_write(logic [2:0] idx, logic [11:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      parse_sb.write_reg(idx, v);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (parse_sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_config(logic [7:0] id, logic [7:0] tmo, logic [7:0] sop,
                             logic [7:0] bop, logic [7:0] mserv, logic [11:0] mhost);
      drain();
      csr_write(CsrDeviceId, {4'd0, id});
      csr_write(CsrRxTimeout, {4'd0, tmo});
      csr_write(CsrSyncReadOp, {4'd0, sop});
      csr_write(CsrBootloadOp, {4'd0, bop});
      csr_write(CsrMaxServoRply, {4'd0, mserv});
      csr_write(CsrMaxHostRply, mhost);
   endtask

   task automatic random_traffic(int goal);
      logic [7:0] p[$];
      logic [7:0] id, own;
      int sel;
      bit bad;
      while (items_sent < goal) begin
         own = parse_sb.cfg.device_id;
         sel = $urandom_range(0, 19);
         bad = ($urandom_range(0, 6) == 0);
         id = ($urandom_range(0, 9) == 0) ? IdBroadcast : own;
         p.delete();
         case (sel)
            0, 1: send_packet(own, OpPing, p, bad);
            2:    send_packet(own, OpReset, p, bad);
            3:    send_packet(own, parse_sb.cfg.boot_op, p, bad);
            4, 5, 6: begin
               repeat ($urandom_range(0, 6)) p.push_back(8'($urandom));
               send_packet(id, ($urandom_range(0, 1) ? OpRead : OpWrite), p, bad);
            end
            7, 8, 9: send_sync_read(id, ($urandom_range(0, 7) == 0) ?
                                     $urandom_range(0, 31) : $urandom_range(0, 5),
                                     8'($urandom_range(0, 12)), bad);
            10, 11: send_foreign();
            12: begin
               // length out of range for the bridge
               send_item(CmdByte, ByteSync);
               send_item(CmdByte, ByteSync);
               send_item(CmdByte, id);
               send_item(CmdByte, ($urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
                                   8'($urandom_range(36, 255))));
            end
            13: begin
               // random instruction, most often an unknown one
               repeat ($urandom_range(0, 3)) p.push_back(8'($urandom));
               send_packet(id, 8'($urandom), p, bad);
            end
            14: begin
               // truncated packet, then ticks: past the timeout when it is below 20, else 1 to 4
               send_item(CmdByte, ByteSync);
               send_item(CmdByte, ByteSync);
               send_item(CmdByte, own);
               if ($urandom_range(0, 1)) send_item(CmdByte, 8'd4);
               send_ticks((parse_sb.cfg.rx_timeout < 20) ? parse_sb.cfg.rx_timeout + 1 :
                          $urandom_range(1, 4));
            end
            15: repeat ($urandom_range(1, 3)) send_item(CmdByte, ByteSync);
            16, 17: send_item(CmdByte, 8'($urandom));
            default: send_ticks($urandom_range(1, 3));
         endcase
      end
   endtask

   initial begin
      logic [7:0] p[$];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(8'd1, 8'd3, 8'd132, 8'd8, 8'd249, 12'd249);
      // directed: every packet type, bad checksum, bad length, foreign id
      send_packet(8'd1, OpPing, p, 0);
      send_packet(8'd1, OpReset, p, 0);
      send_packet(8'd1, 8'd8, p, 0);
      p = '{8'h00, 8'hFF, 8'h80};
      send_packet(8'd1, OpRead, p, 0);
      send_packet(8'd1, OpWrite, p, 0);
      send_sync_read(IdBroadcast, 3, 8'd4, 0);
      send_sync_read(8'd1, 2, 8'd0, 0);
      p.delete();
      send_packet(8'd1, OpPing, p, 1);
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, ByteSync);
      send_item(CmdByte, 8'd1);
      send_item(CmdByte, 8'd255);
      send_foreign();
      repeat (3) send_item(CmdByte, ByteSync);
      send_item(CmdByte, 8'd2);
      send_item(CmdByte, 8'd0);
      send_ticks(5);
      random_traffic(130);

      set_config(8'd0, 8'd0, 8'd255, 8'd0, 8'd1, 12'd1);
      random_traffic(170);
      long_hold = 1;
      random_traffic(200);
      drain();
      random_traffic(230);

      set_config(8'd253, 8'd255, 8'd0, 8'd255, 8'd255, 12'd4095);
      send_sync_read(IdBroadcast, 31, 8'd255, 0);
      random_traffic(300);

      set_config(8'($urandom_range(0, 253)), 8'd2, 8'd132, 8'd8, 8'd20, 12'd60);
      quiet = 1;
      random_traffic(375);

      req_valid <= 1'b0;
      while (parse_sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (parse_sb.errors == 0 && parse_sb.expected_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
